### rtl/core/memory_polynomial_predictor_defines.svh
// assertion macros shared by the checker files
`ifndef MEMORY_POLYNOMIAL_PREDICTOR_DEFINES_SVH
`define MEMORY_POLYNOMIAL_PREDICTOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define MPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mpp_pkg.sv
`default_nettype none

package mpp_pkg;

    // field widths
    localparam int IDX_W      = 7;
    localparam int COEF_W     = 18;
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 24;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;

    // datapath widths
    localparam int ACC_W      = 48;
    localparam int NORM_W     = 32;
    localparam int ROOT_W     = 16;
    localparam int MAG_W      = 17;
    localparam int POW_W      = 20;
    localparam int BASIS_W    = 21;
    localparam int FACTOR_W   = 18;
    localparam int PSI_W      = 38;
    localparam int FRAC_SHIFT = 15;
    localparam int COEF_SHIFT = 13;
    localparam int SQRT_STEPS = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [POW_W-1:0]        POW_ONE = 20'd32768;
    localparam logic signed [ACC_W-1:0] SAT_MAX = 48'sd8388607;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -48'sd8388608;

    typedef enum logic {
        CMD_LOAD,
        CMD_SAMPLE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [IDX_W-1:0]           index;
        logic signed [COEF_W-1:0]   coef_re;
        logic signed [COEF_W-1:0]   coef_im;
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NORM,
        B_SQRT,
        B_POW,
        B_BASIS,
        B_TERM,
        B_ACC,
        B_OUT
    } back_state_t;

    // basis factor a(k,l), argument codes are k-1 and l-1
    function automatic logic signed [FACTOR_W-1:0] basis_factor(
        input logic [2:0] k_idx,
        input logic [2:0] l_idx
    );
        logic signed [FACTOR_W-1:0] v;
        unique case ({k_idx, l_idx})
            6'o00: v = 18'sd1;
            6'o10: v = -18'sd3;
            6'o11: v = 18'sd4;
            6'o20: v = 18'sd6;
            6'o21: v = -18'sd20;
            6'o22: v = 18'sd15;
            6'o30: v = -18'sd10;
            6'o31: v = 18'sd60;
            6'o32: v = -18'sd105;
            6'o33: v = 18'sd56;
            6'o40: v = 18'sd15;
            6'o41: v = -18'sd140;
            6'o42: v = 18'sd420;
            6'o43: v = -18'sd504;
            6'o44: v = 18'sd210;
            6'o50: v = -18'sd21;
            6'o51: v = 18'sd280;
            6'o52: v = -18'sd1260;
            6'o53: v = 18'sd2520;
            6'o54: v = -18'sd2310;
            6'o55: v = 18'sd792;
            6'o60: v = 18'sd28;
            6'o61: v = -18'sd504;
            6'o62: v = 18'sd3150;
            6'o63: v = -18'sd9240;
            6'o64: v = 18'sd13860;
            6'o65: v = -18'sd10296;
            6'o66: v = 18'sd3003;
            6'o70: v = -18'sd36;
            6'o71: v = 18'sd840;
            6'o72: v = -18'sd6930;
            6'o73: v = 18'sd27720;
            6'o74: v = -18'sd60060;
            6'o75: v = 18'sd72072;
            6'o76: v = -18'sd45045;
            6'o77: v = 18'sd11440;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/core/mpp_ram.sv
`default_nettype none

module mpp_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 20,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/mpp_front.sv
`default_nettype none

module mpp_front
    import mpp_pkg::*;
#(
    parameter int COEF_COUNT = 20
) (
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [0:0]           s_axis_tuser,
    input  wire logic                 queue_full,
    output logic                      push,
    output cmd_t                      cmd
);

    logic in_range;

    // unpack the beat into a command
    always_comb
    begin
        cmd.kind      = s_axis_tuser[0] ? CMD_SAMPLE : CMD_LOAD;
        cmd.index     = s_axis_tdata[IDX_W-1:0];
        cmd.coef_re   = s_axis_tdata[IDX_W +: COEF_W];
        cmd.coef_im   = s_axis_tdata[IDX_W+COEF_W +: COEF_W];
        cmd.sample_re = s_axis_tdata[IDX_W+2*COEF_W +: SAMPLE_W];
        cmd.sample_im = s_axis_tdata[IDX_W+2*COEF_W+SAMPLE_W +: SAMPLE_W];
    end

    // loads to a slot past the store are dropped here
    assign in_range      = {1'b0, cmd.index} < (IDX_W+1)'(COEF_COUNT);
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full
                           && (cmd.kind == CMD_SAMPLE || in_range);

endmodule

`default_nettype wire

### rtl/core/mpp_queue.sv
`default_nettype none

module mpp_queue
    import mpp_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mpp_back.sv
`default_nettype none

module mpp_back
    import mpp_pkg::*;
#(
    parameter int ORDER_COUNT  = 5,
    parameter int MEMORY_DEPTH = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  cmd_t                   head,
    input  wire logic              head_valid,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [OUT_W-1:0] model_re,
    output logic signed [OUT_W-1:0] model_im,
    output logic                   clipped
);

    localparam int TAP_COUNT  = MEMORY_DEPTH + 1;
    localparam int COEF_COUNT = TAP_COUNT * ORDER_COUNT;
    localparam int ADDR_W = (COEF_COUNT > 1) ? $clog2(COEF_COUNT) : 1;
    localparam int TAP_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int ORD_W  = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
    localparam int FILL_W = (MEMORY_DEPTH > 0) ? $clog2(MEMORY_DEPTH + 1) : 1;
    localparam int STEP_W = $clog2(SQRT_STEPS);
    localparam int REM_W  = ROOT_W + 3;
    localparam int TPROD_W = POW_W + SAMPLE_W + 1;
    localparam int APROD_W = FACTOR_W + BASIS_W;
    localparam int CPROD_W = PSI_W + COEF_W;

    back_state_t state_reg, state_next;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [TAP_W-1:0]  m_reg, m_next;
    logic [ORD_W-1:0]  k_reg, k_next;
    logic [ORD_W-1:0]  l_reg, l_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [NORM_W-1:0] norm_reg, norm_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [POW_W-1:0]  pw_reg, pw_next;
    logic signed [PSI_W-1:0]   psi_re_reg, psi_re_next;
    logic signed [PSI_W-1:0]   psi_im_reg, psi_im_next;
    logic signed [CPROD_W-1:0] prr_reg, prr_next, pii_reg, pii_next;
    logic signed [CPROD_W-1:0] pri_reg, pri_next, pir_reg, pir_next;
    logic signed [ACC_W-1:0]   acc_re_reg, acc_re_next;
    logic signed [ACC_W-1:0]   acc_im_reg, acc_im_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]   out_re_reg, out_re_next;
    logic signed [OUT_W-1:0]   out_im_reg, out_im_next;
    logic                      out_clip_reg, out_clip_next;

    logic signed [SAMPLE_W-1:0] hist_re_reg [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] hist_im_reg [TAP_COUNT];
    logic signed [BASIS_W-1:0]  t_re_reg [ORDER_COUNT];
    logic signed [BASIS_W-1:0]  t_im_reg [ORDER_COUNT];

    logic                       fill_full, slot_free, shift_en, t_we, ram_we;
    logic                       step_last, l_last, k_last, m_last;
    logic signed [SAMPLE_W-1:0] x_re, x_im;
    logic signed [2*SAMPLE_W-1:0] sq_re, sq_im;
    logic [REM_W-1:0]           rem_shift, trial, rem_step;
    logic [ROOT_W-1:0]          root_step;
    logic [POW_W+MAG_W-1:0]     pw_prod;
    logic signed [TPROD_W-1:0]  t_prod_re, t_prod_im;
    logic signed [BASIS_W-1:0]  t_new_re, t_new_im;
    logic signed [FACTOR_W-1:0] factor;
    logic signed [APROD_W-1:0]  a_prod_re, a_prod_im;
    logic [2*COEF_W-1:0]        ram_rdata;
    logic signed [COEF_W-1:0]   c_re, c_im;
    logic signed [OUT_W-1:0]    sat_re, sat_im;
    logic                       clip_re, clip_im;

    // coefficient store, imaginary part in the upper half
    mpp_ram #(
        .WIDTH (2 * COEF_W),
        .DEPTH (COEF_COUNT)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(head.index)),
        .wdata ({head.coef_im, head.coef_re}),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign c_re = ram_rdata[COEF_W-1:0];
    assign c_im = ram_rdata[2*COEF_W-1:COEF_W];

    // loop status
    assign fill_full = (fill_reg >= FILL_W'(MEMORY_DEPTH));
    assign slot_free = !out_valid_reg || out_ready;
    assign step_last = (step_reg == STEP_W'(SQRT_STEPS - 1));
    assign l_last    = (l_reg == ORD_W'(ORDER_COUNT - 1));
    assign k_last    = (k_reg == ORD_W'(ORDER_COUNT - 1));
    assign m_last    = (m_reg == TAP_W'(MEMORY_DEPTH));

    // current tap sample and its squared magnitude
    assign x_re  = hist_re_reg[m_reg];
    assign x_im  = hist_im_reg[m_reg];
    assign sq_re = x_re * x_re;
    assign sq_im = x_im * x_im;

    // one digit of the square root per cycle
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], norm_reg[NORM_W-1 -: 2]};
        trial     = {{(REM_W-ROOT_W-2){1'b0}}, root_reg, 2'b01};
        if (rem_shift >= trial)
        begin
            rem_step  = rem_shift - trial;
            root_step = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_step  = rem_shift;
            root_step = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    // power and basis products
    assign pw_prod   = pw_reg * mag_reg;
    assign t_prod_re = $signed({1'b0, pw_reg}) * x_re;
    assign t_prod_im = $signed({1'b0, pw_reg}) * x_im;
    assign t_new_re  = t_prod_re[FRAC_SHIFT +: BASIS_W];
    assign t_new_im  = t_prod_im[FRAC_SHIFT +: BASIS_W];
    assign factor    = basis_factor(3'(k_reg), 3'(l_reg));
    assign a_prod_re = factor * t_re_reg[l_reg];
    assign a_prod_im = factor * t_im_reg[l_reg];

    // saturation of the finished sums
    always_comb
    begin
        clip_re = 1'b1;
        clip_im = 1'b1;
        if (acc_re_reg > SAT_MAX)
        begin
            sat_re = OUT_W'(SAT_MAX);
        end
        else if (acc_re_reg < SAT_MIN)
        begin
            sat_re = OUT_W'(SAT_MIN);
        end
        else
        begin
            sat_re  = acc_re_reg[OUT_W-1:0];
            clip_re = 1'b0;
        end
        if (acc_im_reg > SAT_MAX)
        begin
            sat_im = OUT_W'(SAT_MAX);
        end
        else if (acc_im_reg < SAT_MIN)
        begin
            sat_im = OUT_W'(SAT_MIN);
        end
        else
        begin
            sat_im  = acc_im_reg[OUT_W-1:0];
            clip_im = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (head_valid && head.kind == CMD_SAMPLE && fill_full)
                begin
                    state_next = B_NORM;
                end
            end
            B_NORM:  state_next = B_SQRT;
            B_SQRT:
            begin
                if (step_last)
                begin
                    state_next = B_POW;
                end
            end
            B_POW:
            begin
                if (l_last)
                begin
                    state_next = B_BASIS;
                end
            end
            B_BASIS:
            begin
                if (l_reg == k_reg)
                begin
                    state_next = B_TERM;
                end
            end
            B_TERM:  state_next = B_ACC;
            B_ACC:
            begin
                if (!k_last)
                begin
                    state_next = B_BASIS;
                end
                else if (!m_last)
                begin
                    state_next = B_NORM;
                end
                else
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and strobes per state
    always_comb
    begin
        fill_next   = fill_reg;
        m_next      = m_reg;
        k_next      = k_reg;
        l_next      = l_reg;
        step_next   = step_reg;
        addr_next   = addr_reg;
        norm_next   = norm_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        mag_next    = mag_reg;
        pw_next     = pw_reg;
        psi_re_next = psi_re_reg;
        psi_im_next = psi_im_reg;
        prr_next    = prr_reg;
        pii_next    = pii_reg;
        pri_next    = pri_reg;
        pir_next    = pir_reg;
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        out_re_next = out_re_reg;
        out_im_next = out_im_reg;
        out_clip_next = out_clip_reg;
        pop      = 1'b0;
        shift_en = 1'b0;
        t_we     = 1'b0;
        ram_we   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head.kind == CMD_LOAD)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        shift_en = 1'b1;
                        if (!fill_full)
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        else
                        begin
                            m_next      = '0;
                            addr_next   = '0;
                            acc_re_next = '0;
                            acc_im_next = '0;
                        end
                    end
                end
            end
            B_NORM:
            begin
                norm_next = $unsigned(sq_re) + $unsigned(sq_im);
                rem_next  = '0;
                root_next = '0;
                step_next = '0;
            end
            B_SQRT:
            begin
                norm_next = norm_reg << 2;
                rem_next  = rem_step;
                root_next = root_step;
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    // round to nearest
                    mag_next = MAG_W'(root_step) + MAG_W'(rem_step > REM_W'(root_step));
                    pw_next  = POW_ONE;
                    l_next   = '0;
                end
            end
            B_POW:
            begin
                t_we    = 1'b1;
                pw_next = pw_prod[FRAC_SHIFT +: POW_W];
                if (l_last)
                begin
                    l_next      = '0;
                    k_next      = '0;
                    psi_re_next = '0;
                    psi_im_next = '0;
                end
                else
                begin
                    l_next = l_reg + 1'b1;
                end
            end
            B_BASIS:
            begin
                psi_re_next = psi_re_reg + PSI_W'(a_prod_re);
                psi_im_next = psi_im_reg + PSI_W'(a_prod_im);
                if (l_reg != k_reg)
                begin
                    l_next = l_reg + 1'b1;
                end
            end
            B_TERM:
            begin
                prr_next  = psi_re_reg * c_re;
                pii_next  = psi_im_reg * c_im;
                pri_next  = psi_re_reg * c_im;
                pir_next  = psi_im_reg * c_re;
                addr_next = addr_reg + 1'b1;
            end
            B_ACC:
            begin
                acc_re_next = acc_re_reg + ACC_W'(prr_reg >>> COEF_SHIFT)
                              - ACC_W'(pii_reg >>> COEF_SHIFT);
                acc_im_next = acc_im_reg + ACC_W'(pri_reg >>> COEF_SHIFT)
                              + ACC_W'(pir_reg >>> COEF_SHIFT);
                if (!k_last)
                begin
                    k_next      = k_reg + 1'b1;
                    l_next      = '0;
                    psi_re_next = '0;
                    psi_im_next = '0;
                end
                else if (!m_last)
                begin
                    m_next = m_reg + 1'b1;
                end
            end
            B_OUT:
            begin
                if (slot_free)
                begin
                    out_re_next   = sat_re;
                    out_im_next   = sat_im;
                    out_clip_next = clip_re || clip_im;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // result slot holds until taken
    assign out_valid_next = (out_valid_reg && !out_ready) || (state_reg == B_OUT && slot_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        k_reg      <= k_next;
        l_reg      <= l_next;
        step_reg   <= step_next;
        addr_reg   <= addr_next;
        norm_reg   <= norm_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        mag_reg    <= mag_next;
        pw_reg     <= pw_next;
        psi_re_reg <= psi_re_next;
        psi_im_reg <= psi_im_next;
        prr_reg    <= prr_next;
        pii_reg    <= pii_next;
        pri_reg    <= pri_next;
        pir_reg    <= pir_next;
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        out_re_reg <= out_re_next;
        out_im_reg <= out_im_next;
        out_clip_reg <= out_clip_next;
    end

    // sample history shift line, newest at tap zero
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            hist_re_reg[0] <= head.sample_re;
            hist_im_reg[0] <= head.sample_im;
            for (int i = 1; i < TAP_COUNT; i++)
            begin
                hist_re_reg[i] <= hist_re_reg[i-1];
                hist_im_reg[i] <= hist_im_reg[i-1];
            end
        end
    end

    // scaled sample times power of magnitude, one order per cycle
    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            t_re_reg[l_reg] <= t_new_re;
            t_im_reg[l_reg] <= t_new_im;
        end
    end

    assign out_valid = out_valid_reg;
    assign model_re  = out_re_reg;
    assign model_im  = out_im_reg;
    assign clipped   = out_clip_reg;

endmodule

`default_nettype wire

### rtl/core/memory_polynomial_predictor.sv
// Orthogonal memory polynomial predictor. Beats with tuser low load one Q5.13
// complex coefficient into slot tap*ORDER_COUNT+order-1 (slots past the store are
// dropped); beats with tuser high carry a Q1.15 sample, which enters the history
// and, once MEMORY_DEPTH samples came before it, gives one Q9.15 saturated
// result. The time a full sample takes is set by the 16-step square root unit
// and the single complex multiply-accumulate walked over every basis factor and
// coefficient. A two-entry command queue lets input beats land while the engine
// works and an output register holds the result until taken. Coefficient slots
// must be written before a sample reads them.
`default_nettype none

module memory_polynomial_predictor
    import mpp_pkg::*;
#(
    parameter int ORDER_COUNT  = 5,
    parameter int MEMORY_DEPTH = 3
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // coef_index, coef_re, coef_im, sample_re, sample_im, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  wire logic [0:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // model_re, model_im
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // clipped
    output logic [0:0]                 m_axis_tuser
);

    localparam int COEF_COUNT = (MEMORY_DEPTH + 1) * ORDER_COUNT;

    cmd_t                    push_cmd, head;
    logic                    push, queue_full, pop, head_valid;
    logic signed [OUT_W-1:0] model_re, model_im;
    logic                    clipped;

    // accept and classify
    mpp_front #(
        .COEF_COUNT (COEF_COUNT)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    // command queue
    mpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // compute engine
    mpp_back #(
        .ORDER_COUNT  (ORDER_COUNT),
        .MEMORY_DEPTH (MEMORY_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .model_re   (model_re),
        .model_im   (model_im),
        .clipped    (clipped)
    );

    assign m_axis_tdata = {model_im, model_re};
    assign m_axis_tuser = clipped;

endmodule

`default_nettype wire

### rtl/core/mpp_checker.sv
`default_nettype none
`include "memory_polynomial_predictor_defines.svh"

module mpp_checker
    import mpp_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]            m_axis_tuser
);

    // a stalled result beat stays and holds its value
    `MPP_ASSERT_NEXT(a_out_hold,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata),
        "result beat dropped or changed while stalled")

    // the input side only backs up after taking a beat
    `MPP_ASSERT_NOW(a_ready_fall,
        $fell(s_axis_tready),
        $past(s_axis_tvalid && s_axis_tready),
        "input stalled without a prior beat")

    // a clipped result sits on a rail in at least one part
    `MPP_ASSERT_NOW(a_clip_rail,
        m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata[23:0] == 24'h7FFFFF || m_axis_tdata[23:0] == 24'h800000
            || m_axis_tdata[47:24] == 24'h7FFFFF || m_axis_tdata[47:24] == 24'h800000,
        "clipped flag without a saturated part")

    // stalled clip flag holds too
    `MPP_ASSERT_NEXT(a_user_hold,
        m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tuser),
        "clip flag changed while stalled")

endmodule

bind memory_polynomial_predictor mpp_checker u_checker (.*);

`default_nettype wire

### verif/memory_polynomial_predictor_test.sv
`default_nettype none

module memory_polynomial_predictor_test;
    import mpp_pkg::*;

    localparam int ORDERS = 5;
    localparam int TAPS   = 4;
    localparam int SLOTS  = TAPS * ORDERS;

    typedef struct {
        cmd_kind_t   kind;
        logic [6:0]  index;
        int          c_re;
        int          c_im;
        int          s_re;
        int          s_im;
        bit          typed;
        int          y_re;
        int          y_im;
        bit          y_clip;
    } stim_row_t;

    typedef struct {
        int y_re;
        int y_im;
        bit clip;
    } model_out_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    // predictor state
    longint     hist_re [TAPS];
    longint     hist_im [TAPS];
    longint     coef_re_q [SLOTS];
    longint     coef_im_q [SLOTS];
    int         samples_seen;
    model_out_t pending_out [$];

    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_request;

    memory_polynomial_predictor i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // 48-bit two's complement wrap
    function automatic longint wrap48(longint v);
        longint t;
        t = v <<< 16;
        return t >>> 16;
    endfunction

    function automatic longint mul_shift(longint a, longint b, int s);
        return wrap48((a * b) >>> s);
    endfunction

    function automatic longint choose(int n, int r);
        longint v;
        v = 1;
        for (int i = 0; i < r; i++)
            v = v * (n - i) / (i + 1);
        return v;
    endfunction

    // basis factor for order k and power index l, both from one
    function automatic longint psi_factor(int k, int l);
        longint v;
        v = choose(k + l, l - 1) * choose(k + 1, l + 1);
        return ((k + l) % 2 == 1) ? -v : v;
    endfunction

    // rounded integer square root
    function automatic longint magnitude(longint n);
        longint r;
        r = 0;
        for (int b = 17; b >= 0; b--)
            if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= n)
                r = r | (longint'(1) << b);
        if (n - r * r > r)
            r = r + 1;
        return r;
    endfunction

    // apply one accepted beat to the predictor, returns 1 when a result is due
    function automatic bit predict_beat(stim_row_t c, output model_out_t o);
        longint t_re [ORDERS];
        longint t_im [ORDERS];
        longint acc_re, acc_im, pw, mg, pr, pi, cr, ci, a;
        acc_re = 0;
        acc_im = 0;
        o.clip = 1'b0;
        if (c.kind == CMD_LOAD) begin
            if (c.index < SLOTS) begin
                coef_re_q[c.index] = longint'(c.c_re);
                coef_im_q[c.index] = longint'(c.c_im);
            end
            return 1'b0;
        end
        for (int m = TAPS - 1; m > 0; m--) begin
            hist_re[m] = hist_re[m-1];
            hist_im[m] = hist_im[m-1];
        end
        hist_re[0] = longint'(c.s_re);
        hist_im[0] = longint'(c.s_im);
        if (samples_seen < TAPS - 1) begin
            samples_seen++;
            return 1'b0;
        end
        for (int m = 0; m < TAPS; m++) begin
            mg = magnitude(hist_re[m] * hist_re[m] + hist_im[m] * hist_im[m]);
            pw = 32768;
            for (int l = 0; l < ORDERS; l++) begin
                t_re[l] = mul_shift(pw, hist_re[m], 15);
                t_im[l] = mul_shift(pw, hist_im[m], 15);
                pw = mul_shift(pw, mg, 15);
            end
            for (int k = 1; k <= ORDERS; k++) begin
                pr = 0;
                pi = 0;
                for (int l = 1; l <= k; l++) begin
                    a = psi_factor(k, l);
                    pr = wrap48(pr + mul_shift(a, t_re[l-1], 0));
                    pi = wrap48(pi + mul_shift(a, t_im[l-1], 0));
                end
                cr = coef_re_q[m * ORDERS + k - 1];
                ci = coef_im_q[m * ORDERS + k - 1];
                acc_re = wrap48(acc_re + mul_shift(pr, cr, 13));
                acc_re = wrap48(acc_re - mul_shift(pi, ci, 13));
                acc_im = wrap48(acc_im + mul_shift(pr, ci, 13));
                acc_im = wrap48(acc_im + mul_shift(pi, cr, 13));
            end
        end
        // saturate to 24 bits
        if (acc_re > 8388607) begin acc_re = 8388607; o.clip = 1'b1; end
        if (acc_re < -8388608) begin acc_re = -8388608; o.clip = 1'b1; end
        if (acc_im > 8388607) begin acc_im = 8388607; o.clip = 1'b1; end
        if (acc_im < -8388608) begin acc_im = -8388608; o.clip = 1'b1; end
        o.y_re = int'(acc_re);
        o.y_im = int'(acc_im);
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // offer one beat and wait until it is taken
    task automatic send_beat(stim_row_t c);
        model_out_t o;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.kind;
        s_axis_tdata  <= {5'b0, c.s_im[15:0], c.s_re[15:0], c.c_im[17:0], c.c_re[17:0],
                          c.index};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (predict_beat(c, o)) begin
            if (c.typed) begin
                o.y_re = c.y_re;
                o.y_im = c.y_im;
                o.clip = c.y_clip;
            end
            pending_out.push_back(o);
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    function automatic stim_row_t row(cmd_kind_t kind, int index, int c_re, int c_im,
                                      int s_re, int s_im);
        stim_row_t r;
        r.kind   = kind;
        r.index  = 7'(index);
        r.c_re   = c_re;
        r.c_im   = c_im;
        r.s_re   = s_re;
        r.s_im   = s_im;
        r.typed  = 1'b0;
        r.y_re   = 0;
        r.y_im   = 0;
        r.y_clip = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t random_row();
        int span;
        if ($urandom_range(3) == 0)
            return row(CMD_LOAD, $urandom_range(127),
                       ($urandom_range(9) == 0) ? $urandom_range(262143) - 131072
                                                : $urandom_range(800) - 400,
                       ($urandom_range(9) == 0) ? $urandom_range(262143) - 131072
                                                : $urandom_range(800) - 400,
                       $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
        span = ($urandom_range(1) == 0) ? 32768 : 3000;
        return row(CMD_SAMPLE, $urandom_range(127), $urandom_range(262143) - 131072,
                   $urandom_range(262143) - 131072,
                   $urandom_range(2 * span - 1) - span, $urandom_range(2 * span - 1) - span);
    endfunction

    // result side: checks and random stalls
    initial
    begin
        model_out_t want;
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_out.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = pending_out.pop_front();
                    if ($signed(m_axis_tdata[23:0]) != want.y_re)
                        report_mismatch("model_re", int'($signed(m_axis_tdata[23:0])),
                                        want.y_re);
                    if ($signed(m_axis_tdata[47:24]) != want.y_im)
                        report_mismatch("model_im", int'($signed(m_axis_tdata[47:24])),
                                        want.y_im);
                    if (m_axis_tuser[0] != want.clip)
                        report_mismatch("clipped", int'(m_axis_tuser[0]), int'(want.clip));
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // stimulus
    initial
    begin
        stim_row_t dir [$];
        stim_row_t r;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        samples_seen   = 0;
        for (int m = 0; m < TAPS; m++) begin
            hist_re[m] = 0;
            hist_im[m] = 0;
        end
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole coefficient store first
        for (int i = 0; i < SLOTS; i++)
            send_beat(row(CMD_LOAD, i, $urandom_range(800) - 400,
                          $urandom_range(800) - 400, 0, 0));

        // directed part: zero history gives zero, then extremes and dropped slots
        dir.push_back(row(CMD_SAMPLE, 127, -131072, 131071, 0, 0));
        dir.push_back(row(CMD_SAMPLE, 0, 0, 0, 0, 0));
        dir.push_back(row(CMD_SAMPLE, 0, 0, 0, 0, 0));
        r = row(CMD_SAMPLE, 0, 0, 0, 0, 0);
        r.typed = 1'b1;
        dir.push_back(r);
        dir.push_back(row(CMD_LOAD, 127, 131071, -131072, 32767, -32768));
        dir.push_back(row(CMD_LOAD, SLOTS, 131071, 131071, 0, 0));
        dir.push_back(row(CMD_SAMPLE, 5, 1, 1, 32767, 32767));
        dir.push_back(row(CMD_SAMPLE, 0, 0, 0, -32768, -32768));
        dir.push_back(row(CMD_SAMPLE, 0, 0, 0, 32767, -32768));
        dir.push_back(row(CMD_SAMPLE, 0, 0, 0, -32768, 32767));
        dir.push_back(row(CMD_LOAD, 0, 131071, 131071, 0, 0));
        dir.push_back(row(CMD_LOAD, SLOTS - 1, -131072, -131072, 0, 0));
        dir.push_back(row(CMD_SAMPLE, 0, 0, 0, 32767, 0));
        dir.push_back(row(CMD_SAMPLE, 0, 0, 0, 0, -32768));
        dir.push_back(row(CMD_SAMPLE, 0, 0, 0, 1, -1));
        dir.push_back(row(CMD_LOAD, 0, 1, -1, 0, 0));
        dir.push_back(row(CMD_LOAD, SLOTS - 1, 0, 0, 0, 0));
        dir.push_back(row(CMD_SAMPLE, 0, 0, 0, 100, -200));
        foreach (dir[i])
            send_beat(dir[i]);

        // random part in idling phases, first phase holds off the receiver
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 48 : (ph == 3) ? 15 : 0;
            recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 15 : 0;
            if (ph == 0)
                hold_request = 1'b1;
            for (int i = 0; i < 500; i++)
                send_beat(random_row());
            if (ph == 1) begin
                // drain before the next phase
                s_axis_tvalid <= 1'b0;
                while (pending_out.size() != 0)
                    @(posedge clk);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (error_count == 0)
            $display("memory_polynomial_predictor_test OK");
        else
            $display("memory_polynomial_predictor_test NOT OK");
        $finish;
    end

    // run limit
    initial
    begin
        #(20 * 5000000);
        $display("memory_polynomial_predictor_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
